// File: sv/rtdrs_pkg.sv
package rtdrs_pkg;

    localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd800;
    localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd480;
    localparam logic [10:0] CHUNK_RST         = 11'd1024;
    localparam logic [10:0] CHUNK_MIN         = 11'd2;
    localparam logic [10:0] CHUNK_MAX         = 11'd1024;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_CHUNK_BYTES   = 2'd2;
    localparam logic [1:0] REG_SOURCE_BASE   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_OFFS,
        ST_ADDR,
        ST_EMIT,
        ST_STATUS
    } state_t;

    // clipped span along one axis
    typedef struct packed {
        logic        nonempty;
        logic [11:0] lo;
        logic [11:0] span;
    } clip_t;

endpackage

// File: sv/rtdrs_clip.sv
module rtdrs_clip
    import rtdrs_pkg::*;
(
    input  logic [15:0] pos,
    input  logic [15:0] size,
    input  logic [11:0] limit,
    output clip_t       clip
);

    logic signed [16:0] end_s;
    logic signed [16:0] hi_s;
    logic signed [16:0] lo_s;
    logic signed [16:0] diff_s;
    logic        [14:0] lo_u;

    always_comb
    begin
        // full-width signed math, no 16-bit wrap
        end_s  = $signed({pos[15], pos}) + $signed({size[15], size});
        lo_u   = pos[15] ? 15'd0 : pos[14:0];
        lo_s   = $signed({2'b00, lo_u});
        hi_s   = (end_s > $signed({5'b00000, limit})) ? $signed({5'b00000, limit}) : end_s;
        diff_s = hi_s - lo_s;
        clip.nonempty = hi_s > lo_s;
        clip.lo       = lo_u[11:0];
        clip.span     = diff_s[11:0];
    end

endmodule

// File: sv/rect_to_dma_row_segments.sv
// Accept, then setup in SETUP (clip, row offset multiply), OFFS (offset add) and
// ADDR (source add), then one copy-job word per cycle while the output is not
// stalled. A full queue with chunks left ends the rectangle with status set in
// its status word; an empty rectangle goes straight to the status word.
// The next rectangle is taken once the status word is loaded.
// Reset clears control state and loads the config registers with their defaults.
module rect_to_dma_row_segments
    import rtdrs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] rect_x, [31:16] rect_y, [47:32] rect_w, [63:48] rect_h,
    // [69:64] free_slots, [71:70] zero
    input  logic [71:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] src_address, [56:32] dest_offset, [67:57] job_length,
    // [68] status, [71:69] zero
    output logic [71:0] m_tdata,
    // [0] job_valid
    output logic [0:0]  m_tuser,
    output logic        m_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = $clog2(QUEUE_DEPTH + 1);

    // configuration
    logic [11:0] sw_reg;
    logic [11:0] sh_reg;
    logic [10:0] chunk_cfg_reg;
    logic [31:0] base_reg;
    logic        cfg_wr;

    // sequencer
    state_t      state_reg, state_next;
    logic [15:0] in_x_reg, in_x_next;
    logic [15:0] in_y_reg, in_y_next;
    logic [15:0] in_w_reg, in_w_next;
    logic [15:0] in_h_reg, in_h_next;
    logic [5:0]  in_slots_reg, in_slots_next;
    logic [10:0] chunk_reg, chunk_next;
    logic [SW-1:0] slots_left_reg, slots_left_next;
    logic [11:0] rows_left_reg, rows_left_next;
    logic [12:0] row_bytes_reg, row_bytes_next;
    logic [12:0] rem_reg, rem_next;
    logic [23:0] prod_reg, prod_next;
    logic [11:0] lo_x_reg, lo_x_next;
    logic [12:0] stride_reg, stride_next;
    logic [24:0] row_start_reg, row_start_next;
    logic [31:0] src_row_reg, src_row_next;
    logic [24:0] pos_reg, pos_next;
    logic [31:0] src_reg, src_next;
    logic        status_reg, status_next;

    // output word
    logic        out_valid_reg, out_valid_next;
    logic        out_job_reg, out_job_next;
    logic [31:0] out_src_reg, out_src_next;
    logic [24:0] out_dest_reg, out_dest_next;
    logic [10:0] out_len_reg, out_len_next;
    logic        out_status_reg, out_status_next;
    logic        out_last_reg, out_last_next;

    clip_t       clip_x;
    clip_t       clip_y;
    logic        out_free;
    logic [10:0] chunk_clamped;
    logic [10:0] len;
    logic [24:0] pos_row;
    logic [31:0] src_rowstep;

    rtdrs_clip u_clip_x (
        .pos   (in_x_reg),
        .size  (in_w_reg),
        .limit (sw_reg),
        .clip  (clip_x)
    );

    rtdrs_clip u_clip_y (
        .pos   (in_y_reg),
        .size  (in_h_reg),
        .limit (sh_reg),
        .clip  (clip_y)
    );

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg        <= SCREEN_WIDTH_RST;
            sh_reg        <= SCREEN_HEIGHT_RST;
            chunk_cfg_reg <= CHUNK_RST;
            base_reg      <= 32'd0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_SCREEN_WIDTH:  sw_reg        <= pwdata[11:0];
                REG_SCREEN_HEIGHT: sh_reg        <= pwdata[11:0];
                REG_CHUNK_BYTES:   chunk_cfg_reg <= pwdata[10:0];
                REG_SOURCE_BASE:   base_reg      <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SCREEN_WIDTH:  prdata = {20'd0, sw_reg};
            REG_SCREEN_HEIGHT: prdata = {20'd0, sh_reg};
            REG_CHUNK_BYTES:   prdata = {21'd0, chunk_cfg_reg};
            REG_SOURCE_BASE:   prdata = base_reg;
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        if (chunk_cfg_reg < CHUNK_MIN)
            chunk_clamped = CHUNK_MIN;
        else if (chunk_cfg_reg > CHUNK_MAX)
            chunk_clamped = CHUNK_MAX;
        else
            chunk_clamped = chunk_cfg_reg;
    end

    assign len         = (rem_reg > {2'b00, chunk_reg}) ? chunk_reg : rem_reg[10:0];
    assign pos_row     = row_start_reg + {12'd0, stride_reg};
    assign src_rowstep = src_row_reg + {19'd0, stride_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_x_reg       <= in_x_next;
        in_y_reg       <= in_y_next;
        in_w_reg       <= in_w_next;
        in_h_reg       <= in_h_next;
        in_slots_reg   <= in_slots_next;
        chunk_reg      <= chunk_next;
        slots_left_reg <= slots_left_next;
        rows_left_reg  <= rows_left_next;
        row_bytes_reg  <= row_bytes_next;
        rem_reg        <= rem_next;
        prod_reg       <= prod_next;
        lo_x_reg       <= lo_x_next;
        stride_reg     <= stride_next;
        row_start_reg  <= row_start_next;
        src_row_reg    <= src_row_next;
        pos_reg        <= pos_next;
        src_reg        <= src_next;
        status_reg     <= status_next;
        out_job_reg    <= out_job_next;
        out_src_reg    <= out_src_next;
        out_dest_reg   <= out_dest_next;
        out_len_reg    <= out_len_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        in_x_next       = in_x_reg;
        in_y_next       = in_y_reg;
        in_w_next       = in_w_reg;
        in_h_next       = in_h_reg;
        in_slots_next   = in_slots_reg;
        chunk_next      = chunk_reg;
        slots_left_next = slots_left_reg;
        rows_left_next  = rows_left_reg;
        row_bytes_next  = row_bytes_reg;
        rem_next        = rem_reg;
        prod_next       = prod_reg;
        lo_x_next       = lo_x_reg;
        stride_next     = stride_reg;
        row_start_next  = row_start_reg;
        src_row_next    = src_row_reg;
        pos_next        = pos_reg;
        src_next        = src_reg;
        status_next     = status_reg;

        out_valid_next  = out_valid_reg && !m_tready;
        out_job_next    = out_job_reg;
        out_src_next    = out_src_reg;
        out_dest_next   = out_dest_reg;
        out_len_next    = out_len_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    in_x_next     = s_tdata[15:0];
                    in_y_next     = s_tdata[31:16];
                    in_w_next     = s_tdata[47:32];
                    in_h_next     = s_tdata[63:48];
                    in_slots_next = s_tdata[69:64];
                    state_next    = ST_SETUP;
                end
            end

            ST_SETUP:
            begin
                status_next    = 1'b0;
                chunk_next     = chunk_clamped;
                if (int'(in_slots_reg) > QUEUE_DEPTH)
                    slots_left_next = SW'(QUEUE_DEPTH);
                else
                    slots_left_next = SW'(in_slots_reg);
                rows_left_next = clip_y.span;
                row_bytes_next = {clip_x.span, 1'b0};
                rem_next       = {clip_x.span, 1'b0};
                lo_x_next      = clip_x.lo;
                stride_next    = {sw_reg, 1'b0};
                prod_next      = {12'd0, clip_y.lo} * {12'd0, sw_reg};
                if (clip_x.nonempty && clip_y.nonempty)
                    state_next = ST_OFFS;
                else
                    state_next = ST_STATUS;
            end

            ST_OFFS:
            begin
                row_start_next = {prod_reg + {12'd0, lo_x_reg}, 1'b0};
                pos_next       = {prod_reg + {12'd0, lo_x_reg}, 1'b0};
                state_next     = ST_ADDR;
            end

            ST_ADDR:
            begin
                src_row_next = base_reg + {7'd0, row_start_reg};
                src_next     = base_reg + {7'd0, row_start_reg};
                state_next   = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (slots_left_reg == '0)
                    begin
                        // chunks left but no queue room
                        status_next = 1'b1;
                        state_next  = ST_STATUS;
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        out_job_next    = 1'b1;
                        out_src_next    = src_reg;
                        out_dest_next   = pos_reg;
                        out_len_next    = len;
                        out_status_next = 1'b0;
                        out_last_next   = 1'b0;
                        slots_left_next = slots_left_reg - SW'(1);
                        if (rem_reg == {2'b00, len})
                        begin
                            if (rows_left_reg == 12'd1)
                                state_next = ST_STATUS;
                            rows_left_next = rows_left_reg - 12'd1;
                            rem_next       = row_bytes_reg;
                            row_start_next = pos_row;
                            pos_next       = pos_row;
                            src_row_next   = src_rowstep;
                            src_next       = src_rowstep;
                        end
                        else
                        begin
                            rem_next = rem_reg - {2'b00, len};
                            pos_next = pos_reg + {14'd0, len};
                            src_next = src_reg + {21'd0, len};
                        end
                    end
                end
            end

            ST_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_job_next    = 1'b0;
                    out_src_next    = 32'd0;
                    out_dest_next   = 25'd0;
                    out_len_next    = 11'd0;
                    out_status_next = status_reg;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_status_reg, out_len_reg, out_dest_reg, out_src_reg};
    assign m_tuser  = out_job_reg;
    assign m_tlast  = out_last_reg;

    // ---------------- checks ----------------
    a_job_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (!m_tlast && !m_tdata[68]))
        else $error("job word flagged as last or with status");

    a_job_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[67:57] != 11'd0 && m_tdata[67:57] <= chunk_reg))
        else $error("job length zero or above chunk size");

    a_slot_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && slots_left_reg != '0) |=>
        (out_valid_reg && out_job_reg))
        else $error("job not loaded while slots remain");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second rectangle taken during processing");

endmodule
